// File: src/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg - shared types and constants of the lcd nibble sequencer
// commands, strobe record and the fixed instruction bytes
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

  localparam int unsigned WaitW    = 13;
  localparam int unsigned ByteWaitW = 8;
  localparam int unsigned IdxW     = 4;

  localparam logic [WaitW-1:0] WaitMax       = 13'd8191;
  localparam logic [WaitW-1:0] InitFirstWait = 13'd5000;
  localparam logic [WaitW-1:0] InitNextWait  = 13'd100;
  localparam logic [9:0]       NumberMax     = 10'd999;
  localparam logic [3:0]       AsciiDigitHi  = 4'h3;   // high nibble of '0'..'9'
  localparam logic [3:0]       WakeNibble    = 4'h3;
  localparam logic [3:0]       FourBitNibble = 4'h2;
  localparam logic [IdxW-1:0]  InitBareCnt   = 4'd4;
  localparam logic [IdxW-1:0]  InitLastIdx   = 4'd13;
  localparam logic [2:0]       ClearFirstByte = 3'd3;  // position of clear in the byte table

  localparam logic [0:0] CfgByteWait  = 1'b0;
  localparam logic [0:0] CfgClearWait = 1'b1;
  localparam logic [WaitW-1:0] ByteWaitReset  = 13'd50;
  localparam logic [WaitW-1:0] ClearWaitReset = 13'd2000;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_INSTR  = 3'd1,
    OP_DATA   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_CURSOR = 3'd4,
    OP_NUMBER = 3'd5
  } op_t;

  // command held while its strobes go out
  typedef struct packed {
    op_t        op;
    logic [7:0] byte_val;   // instruction, data or cursor byte
    logic [3:0] hund;       // hundreds digit
    logic [6:0] rem;        // number mod 100
  } cmd_t;

  typedef struct packed {
    logic             reg_select;
    logic [3:0]       nibble;
    logic [WaitW-1:0] wait_us;
    logic             last;
  } strobe_t;

  // init instruction bytes followed by clear and home
  function automatic logic [7:0] setup_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'b0010_1000;
      3'd1:    b = 8'b0000_0110;
      3'd2:    b = 8'b0000_1100;
      3'd3:    b = 8'b0000_0001;
      3'd4:    b = 8'b0000_0010;
      default: b = 8'b0000_0000;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/lcdns_cfg_regs.sv
// ----------------------------------------------------------------------------
// lcdns_cfg_regs - wait configuration registers
// byte wait and clear wait, written over the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_cfg_regs
  import lcdns_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [WaitW-1:0] cfg_data,
  output logic [ByteWaitW-1:0]  byte_wait,
  output logic [WaitW-1:0]      clear_wait
);

  logic [ByteWaitW-1:0] byte_wait_r, byte_wait_nxt;
  logic [WaitW-1:0]     clear_wait_r, clear_wait_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    byte_wait_nxt  = byte_wait_r;
    clear_wait_nxt = clear_wait_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CfgByteWait:  byte_wait_nxt  = cfg_data[ByteWaitW-1:0];
        CfgClearWait: clear_wait_nxt = cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_wait_r  <= ByteWaitReset[ByteWaitW-1:0];
      clear_wait_r <= ClearWaitReset;
    end else begin
      byte_wait_r  <= byte_wait_nxt;
      clear_wait_r <= clear_wait_nxt;
    end
  end

  assign byte_wait  = byte_wait_r;
  assign clear_wait = clear_wait_r;

endmodule

`default_nettype wire

// File: src/lcdns_cmd_stage.sv
// ----------------------------------------------------------------------------
// lcdns_cmd_stage - command register and strobe counter
// captures a command, splits off the hundreds digit, steps the strobe index
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_cmd_stage
  import lcdns_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_operation,
  input  wire logic [7:0]      in_byte_value,
  input  wire logic [5:0]      in_column,
  input  wire logic [0:0]      in_row,
  input  wire logic [9:0]      in_number,
  input  wire logic            advance,     // output slot free this cycle
  input  wire logic            strobe_last, // current strobe ends the command
  output cmd_t                 cmd,
  output logic                 cmd_valid,
  output logic [IdxW-1:0]      idx
);

  cmd_t            cmd_r, cmd_nxt;
  logic            cmd_valid_r, cmd_valid_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;

  logic            accept, load, step;
  logic [9:0]      num_sat;
  logic [15:0]     hund_prod;
  logic [3:0]      hund;
  logic [10:0]     hund_scaled;
  logic [9:0]      rem_full;

  assign step     = cmd_valid_r && advance;
  assign in_stall = cmd_valid_r && !(advance && strobe_last);
  assign accept   = in_valid && !in_stall;
  assign load     = accept && (in_operation <= 3'(OP_NUMBER));

  // n / 100 as (n * 41) >> 12, exact below 1000
  assign num_sat     = (in_number > NumberMax) ? NumberMax : in_number;
  assign hund_prod   = 16'(num_sat) * 16'd41;
  assign hund        = hund_prod[15:12];
  assign hund_scaled = 11'(hund) * 11'd100;
  assign rem_full    = num_sat - hund_scaled[9:0];

  always_comb begin
    cmd_nxt       = cmd_r;
    cmd_valid_nxt = cmd_valid_r;
    idx_nxt       = idx_r;
    if (step) begin
      idx_nxt = idx_r + 1'b1;
      if (strobe_last) begin
        cmd_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      cmd_valid_nxt    = 1'b1;
      idx_nxt          = '0;
      cmd_nxt.op       = op_t'(in_operation);
      cmd_nxt.byte_val = (op_t'(in_operation) == OP_CURSOR) ?
                         {1'b1, in_row, in_column} : in_byte_value;
      cmd_nxt.hund     = hund;
      cmd_nxt.rem      = rem_full[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd       = cmd_r;
  assign cmd_valid = cmd_valid_r;
  assign idx       = idx_r;

endmodule

`default_nettype wire

// File: src/lcdns_strobe_gen.sv
// ----------------------------------------------------------------------------
// lcdns_strobe_gen - strobe decoder
// turns the held command and strobe index into one enable strobe
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_strobe_gen
  import lcdns_pkg::*;
(
  input  wire cmd_t                  cmd,
  input  wire logic [IdxW-1:0]       idx,
  input  wire logic [ByteWaitW-1:0]  byte_wait,
  input  wire logic [WaitW-1:0]      clear_wait,
  output strobe_t                    strobe
);

  logic [14:0]     tens_prod;
  logic [3:0]      tens, units;
  logic [7:0]      tens_scaled;
  logic [1:0]      n_bytes;
  logic [1:0]      digit_pos;
  logic [3:0]      digit;
  logic [2:0]      byte_pos;
  logic [IdxW-1:0] init_off;
  logic [7:0]      cur_byte;
  logic            bare, add_clear, rs;
  logic [3:0]      bare_nib;
  logic [WaitW-1:0] bare_wait;
  logic [IdxW-1:0] last_idx;
  logic [WaitW:0]  wait_sum;
  logic [WaitW-1:0] byte_wait_total;

  // rem / 10 as (rem * 205) >> 11, exact below 100
  assign tens_prod   = 15'(cmd.rem) * 15'd205;
  assign tens        = tens_prod[14:11];
  assign tens_scaled = 8'(tens) * 8'd10;
  assign units       = 4'(8'(cmd.rem) - tens_scaled);

  // leading zero suppression
  always_comb begin
    if (cmd.hund != '0) begin
      n_bytes = 2'd3;
    end else if (tens != '0) begin
      n_bytes = 2'd2;
    end else begin
      n_bytes = 2'd1;
    end
  end

  assign init_off  = idx - InitBareCnt;
  assign digit_pos = 2'(idx[IdxW-1:1]) + (2'd3 - n_bytes);

  always_comb begin
    unique case (digit_pos)
      2'd0:    digit = cmd.hund;
      2'd1:    digit = tens;
      default: digit = units;
    endcase
  end

  always_comb begin
    bare      = 1'b0;
    bare_nib  = WakeNibble;
    bare_wait = InitNextWait;
    byte_pos  = '0;
    cur_byte  = cmd.byte_val;
    add_clear = 1'b0;
    rs        = 1'b0;
    last_idx  = 4'd1;
    unique case (cmd.op)
      OP_INIT: begin
        last_idx = InitLastIdx;
        if (idx < InitBareCnt) begin
          bare = 1'b1;
          if (idx == '0) begin
            bare_wait = InitFirstWait;
          end
          if (idx == InitBareCnt - 1'b1) begin
            bare_nib = FourBitNibble;
          end
        end
        byte_pos  = init_off[3:1];
        cur_byte  = setup_byte(byte_pos);
        add_clear = (byte_pos >= ClearFirstByte);
      end
      OP_INSTR, OP_CURSOR: begin
        rs = 1'b0;
      end
      OP_DATA: begin
        rs = 1'b1;
      end
      OP_CLEAR: begin
        last_idx  = 4'd3;
        byte_pos  = ClearFirstByte + 3'(idx[IdxW-1:1]);
        cur_byte  = setup_byte(byte_pos);
        add_clear = 1'b1;
      end
      OP_NUMBER: begin
        rs       = 1'b1;
        last_idx = {1'b0, n_bytes, 1'b1} - 4'd2;
        cur_byte = {AsciiDigitHi, digit};
      end
      default: ;
    endcase
  end

  // second nibble wait, saturated
  assign wait_sum = (WaitW+1)'(byte_wait) +
                    (add_clear ? (WaitW+1)'(clear_wait) : '0);
  assign byte_wait_total = (wait_sum > (WaitW+1)'(WaitMax)) ? WaitMax : wait_sum[WaitW-1:0];

  always_comb begin
    strobe.reg_select = rs;
    strobe.last       = (idx == last_idx);
    if (bare) begin
      strobe.nibble  = bare_nib;
      strobe.wait_us = bare_wait;
    end else if (idx[0]) begin
      strobe.nibble  = cur_byte[3:0];
      strobe.wait_us = byte_wait_total;
    end else begin
      strobe.nibble  = cur_byte[7:4];
      strobe.wait_us = '0;
    end
  end

endmodule

`default_nettype wire

// File: src/lcd_4bit_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_4bit_nibble_sequencer - 4-bit character display strobe sequencer
// expands one display command into its run of enable strobes
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one command per transfer (valid/stall); ops 6 and 7 are taken
//           and dropped without strobes
//   out_* : one strobe per transfer (valid/stall), out_last marks the final
//           strobe of a command
//   cfg_* : register writes (valid/ready, always ready), index 0 byte wait,
//           index 1 clear wait
// output: the first strobe of a command passes through the command register and
//   then the output register; strobes then follow one per cycle while out_stall is low
// occupancy: a command holds the command register while its strobes, 2 to 14
//   (init), go out; the next command is taken in the cycle the last strobe of the
//   previous one moves to the output register
// a stall on the output holds the output register and the strobe counter,
//   and the input stalls while a command is still pending
// reset clears the command and output valid flags and loads the waits with
//   50 us and 2000 us
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_4bit_nibble_sequencer
  import lcdns_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [5:0]  in_column,
  input  wire logic [0:0]  in_row,
  input  wire logic [9:0]  in_number,
  // strobe channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_reg_select,
  output logic [3:0]       out_nibble,
  output logic [12:0]      out_wait_us,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  logic [ByteWaitW-1:0] byte_wait;
  logic [WaitW-1:0]     clear_wait;
  cmd_t                 cmd;
  logic                 cmd_valid;
  logic [IdxW-1:0]      idx;
  strobe_t              strobe;
  logic                 advance;

  strobe_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;

  lcdns_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_wait  (byte_wait),
    .clear_wait (clear_wait)
  );

  lcdns_cmd_stage u_cmd (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_byte_value (in_byte_value),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_number     (in_number),
    .advance       (advance),
    .strobe_last   (strobe.last),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .idx           (idx)
  );

  lcdns_strobe_gen u_gen (
    .cmd        (cmd),
    .idx        (idx),
    .byte_wait  (byte_wait),
    .clear_wait (clear_wait),
    .strobe     (strobe)
  );

  // output slot can take a strobe when empty or being drained
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = cmd_valid;
      if (cmd_valid) begin
        out_nxt = strobe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_r.reg_select;
  assign out_nibble     = out_r.nibble;
  assign out_wait_us    = out_r.wait_us;
  assign out_last       = out_r.last;

endmodule

`default_nettype wire
